/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/utf8tc_pkg.sv */
// Shared types and constants of the UTF-16/UTF-32 to UTF-8 transcoder.
`default_nettype none

package utf8tc_pkg;

  localparam int PADDR_W = 3;

  localparam logic [2:0] ST_BYTE        = 3'd0;
  localparam logic [2:0] ST_CLEAN       = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE  = 3'd2;
  localparam logic [2:0] ST_ILLFORMED   = 3'd3;
  localparam logic [2:0] ST_UNENCODABLE = 3'd4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic        is_status;
    logic [2:0]  status;
    logic [30:0] code;
  } job_t;

endpackage

`default_nettype wire

/* rtl/utf8tc_front.sv */
// Front end: gathers code unit bytes, pairs surrogates and queues code points or status.
`default_nettype none

module utf8tc_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  src_valid,
  output logic                 src_stall,
  input  utf8tc_pkg::in_word_t src_word,
  input  wire  [1:0]           encoding_mode,
  input  wire                  cfg_clear,
  input  wire                  q_full,
  output logic                 push,
  output utf8tc_pkg::job_t     push_job
);

  localparam logic       CMD_END   = 1'b1;
  localparam logic [5:0] HIGH_TAG  = 6'b110110;
  localparam logic [5:0] LOW_TAG   = 6'b110111;
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam int         UTF32_BIT = 1;
  localparam int         BIG_BIT   = 0;

  logic [31:0] unit_buffer, unit_buffer_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [2:0]  error_code, error_code_next;

  logic        accept;
  logic [31:0] buf_shift;
  logic [2:0]  cnt_inc;
  logic [15:0] lo16, hi16;
  logic [31:0] w32;
  logic [30:0] pair;
  logic        big;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  assign src_stall = q_full;
  assign accept    = src_valid && !q_full;
  assign big       = encoding_mode[BIG_BIT];

  always_comb begin
    buf_shift = {unit_buffer[23:0], src_word.data_byte};
    cnt_inc   = byte_count + 3'd1;
    lo16      = big ? buf_shift[15:0]  : swap16(buf_shift[15:0]);
    hi16      = big ? buf_shift[31:16] : swap16(buf_shift[31:16]);
    w32       = big ? buf_shift : swap32(buf_shift);
    pair      = {11'd0, hi16[9:0], lo16[9:0]} + 31'h0001_0000;

    unit_buffer_next = unit_buffer;
    byte_count_next  = byte_count;
    error_code_next  = error_code;
    push             = 1'b0;
    push_job         = '0;

    if (cfg_clear) begin
      unit_buffer_next = '0;
      byte_count_next  = '0;
    end else if (accept) begin
      if (src_word.cmd == CMD_END) begin
        push               = 1'b1;
        push_job.is_status = 1'b1;
        if (error_code != ERR_NONE) begin
          push_job.status = error_code;
        end else if (byte_count != 3'd0) begin
          push_job.status = utf8tc_pkg::ST_INCOMPLETE;
        end else begin
          push_job.status = utf8tc_pkg::ST_CLEAN;
        end
        unit_buffer_next = '0;
        byte_count_next  = '0;
        error_code_next  = ERR_NONE;
      end else if (error_code == ERR_NONE) begin
        unit_buffer_next = buf_shift;
        byte_count_next  = cnt_inc;
        if (!encoding_mode[UTF32_BIT]) begin
          if (cnt_inc == 3'd2 && lo16[15:10] != HIGH_TAG) begin
            push             = 1'b1;
            unit_buffer_next = '0;
            byte_count_next  = '0;
            if (lo16[15:10] == LOW_TAG) begin
              push_job.is_status = 1'b1;
              push_job.status    = utf8tc_pkg::ST_ILLFORMED;
              error_code_next    = utf8tc_pkg::ST_ILLFORMED;
            end else begin
              push_job.status = utf8tc_pkg::ST_BYTE;
              push_job.code   = {15'd0, lo16};
            end
          end else if (cnt_inc == 3'd4) begin
            push             = 1'b1;
            unit_buffer_next = '0;
            byte_count_next  = '0;
            if (lo16[15:10] != LOW_TAG) begin
              push_job.is_status = 1'b1;
              push_job.status    = utf8tc_pkg::ST_ILLFORMED;
              error_code_next    = utf8tc_pkg::ST_ILLFORMED;
            end else begin
              push_job.status = utf8tc_pkg::ST_BYTE;
              push_job.code   = pair;
            end
          end
        end else if (cnt_inc == 3'd4) begin
          push             = 1'b1;
          unit_buffer_next = '0;
          byte_count_next  = '0;
          if (w32[31]) begin
            push_job.is_status = 1'b1;
            push_job.status    = utf8tc_pkg::ST_UNENCODABLE;
            error_code_next    = utf8tc_pkg::ST_UNENCODABLE;
          end else begin
            push_job.status = utf8tc_pkg::ST_BYTE;
            push_job.code   = w32[30:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_buffer <= '0;
      byte_count  <= '0;
      error_code  <= ERR_NONE;
    end else begin
      unit_buffer <= unit_buffer_next;
      byte_count  <= byte_count_next;
      error_code  <= error_code_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8tc_queue.sv */
// Short queue of code point and status jobs between the front and back ends.
`default_nettype none

module utf8tc_queue #(
  parameter int DEPTH = 2
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  utf8tc_pkg::job_t       push_job,
  output logic                   full,
  output logic                   head_valid,
  output utf8tc_pkg::job_t       head_job,
  input  wire                    pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  utf8tc_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8tc_back.sv */
// Back end: turns queued jobs into UTF-8 or status words, one per cycle unless stalled.
`default_nettype none

module utf8tc_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   head_valid,
  input  utf8tc_pkg::job_t      head_job,
  output logic                  pop,
  output logic                  dst_valid,
  input  wire                   dst_stall,
  output utf8tc_pkg::out_word_t dst_word
);

  logic [2:0]  idx, idx_next;
  logic [2:0]  nbytes;
  logic [2:0]  rem;
  logic [4:0]  shamt;
  logic [30:0] shifted;
  logic        last_byte;
  logic        out_load;
  logic        emit;
  utf8tc_pkg::out_word_t word_next;

  function automatic logic [7:0] lead_mark(input logic [2:0] n);
    case (n)
      3'd2:    lead_mark = 8'hC0;
      3'd3:    lead_mark = 8'hE0;
      3'd4:    lead_mark = 8'hF0;
      3'd5:    lead_mark = 8'hF8;
      default: lead_mark = 8'hFC;
    endcase
  endfunction

  always_comb begin
    if (head_job.code < 31'h80) begin
      nbytes = 3'd1;
    end else if (head_job.code < 31'h800) begin
      nbytes = 3'd2;
    end else if (head_job.code < 31'h1_0000) begin
      nbytes = 3'd3;
    end else if (head_job.code < 31'h20_0000) begin
      nbytes = 3'd4;
    end else if (head_job.code < 31'h400_0000) begin
      nbytes = 3'd5;
    end else begin
      nbytes = 3'd6;
    end
    rem       = nbytes - 3'd1 - idx;
    shamt     = 5'({rem, 2'b00}) + 5'({rem, 1'b0});
    shifted   = head_job.code >> shamt;
    last_byte = head_job.is_status || (idx == nbytes - 3'd1);

    word_next.last   = last_byte;
    word_next.status = head_job.status;
    if (head_job.is_status) begin
      word_next.out_byte = 8'h00;
    end else if (nbytes == 3'd1) begin
      word_next.out_byte = head_job.code[7:0];
    end else if (idx == 3'd0) begin
      word_next.out_byte = shifted[7:0] | lead_mark(nbytes);
    end else begin
      word_next.out_byte = {2'b10, shifted[5:0]};
    end
  end

  assign out_load = !dst_valid || !dst_stall;
  assign emit     = head_valid && out_load;
  assign pop      = emit && last_byte;

  always_comb begin
    idx_next = idx;
    if (pop) begin
      idx_next = 3'd0;
    end else if (emit) begin
      idx_next = idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      dst_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (out_load) begin
        dst_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dst_word <= word_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf16_utf32_to_utf8_transcoder.sv */
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder with its register port.
// The block takes one input word per cycle while its job queue has room. A code
// point leaves as one to six UTF-8 words and a status item as one word; the
// back end emits one output word per cycle while the output is not stalled, and
// a four-byte UTF-16 pair or UTF-32 unit yields at most six words. A
// QUEUE_DEPTH-entry queue lets the front keep taking bytes while the back end
// and the output register wait on a stalled sink. The encoding_mode register
// sits at byte address 0 and should be written only while the block is idle; a
// write drops any partially gathered code unit.
`default_nettype none

module utf16_utf32_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   src_valid,
  output logic                                  src_stall,
  input  utf8tc_pkg::in_word_t                  src_word,
  output logic                                  dst_valid,
  input  wire                                   dst_stall,
  output utf8tc_pkg::out_word_t                 dst_word,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [utf8tc_pkg::PADDR_W-1:0]        paddr,
  input  wire  [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam logic [utf8tc_pkg::PADDR_W-3:0] REG_ENCODING_MODE = '0;

  logic [1:0]       encoding_mode;
  logic             reg_hit;
  logic             cfg_write;
  logic             q_full;
  logic             push;
  logic             pop;
  logic             head_valid;
  utf8tc_pkg::job_t push_job;
  utf8tc_pkg::job_t head_job;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[utf8tc_pkg::PADDR_W-1:2] == REG_ENCODING_MODE);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? {30'd0, encoding_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= 2'd0;
    end else if (cfg_write) begin
      encoding_mode <= pwdata[1:0];
    end
  end

  utf8tc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .src_word      (src_word),
    .encoding_mode (encoding_mode),
    .cfg_clear     (cfg_write),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  utf8tc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  utf8tc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .dst_word   (dst_word)
  );

endmodule

`default_nettype wire

/* rtl/utf8tc_checker.sv */
// Port-level assertions for the transcoder and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"

module utf8tc_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        dst_valid,
  input wire                        dst_stall,
  input utf8tc_pkg::out_word_t      dst_word
);

  `ASSERT_RST(a_dst_hold, dst_valid && dst_stall |=> dst_valid, "Output word dropped while stalled")
  `ASSERT_RST(a_dst_stable, dst_valid && dst_stall |=> $stable(dst_word), "Stalled output word changed")
  `ASSERT_RST(a_status_form, dst_valid && dst_word.status != utf8tc_pkg::ST_BYTE |-> dst_word.last && dst_word.out_byte == 8'h00, "Status word not last or not zero")
  `ASSERT_RST(a_ascii_last, dst_valid && dst_word.status == utf8tc_pkg::ST_BYTE && !dst_word.out_byte[7] |-> dst_word.last, "Single-byte character not marked last")

endmodule

bind utf16_utf32_to_utf8_transcoder utf8tc_checker u_checker (.*);

`default_nettype wire

/* verif/tb_utf16_utf32_to_utf8_transcoder.sv */
// Self-checking testbench for the UTF-16/UTF-32 to UTF-8 transcoder.
module tb_utf16_utf32_to_utf8_transcoder;

  localparam logic [1:0] MODE_UTF16LE = 2'd0;
  localparam logic [1:0] MODE_UTF16BE = 2'd1;
  localparam logic [1:0] MODE_UTF32LE = 2'd2;
  localparam logic [1:0] MODE_UTF32BE = 2'd3;

  localparam logic [utf8tc_pkg::PADDR_W-1:0] ENC_MODE_ADDR = 3'd0;
  localparam logic [utf8tc_pkg::PADDR_W-1:0] SPARE_ADDR    = 3'd4;

  localparam logic [2:0] NO_ERROR = 3'd0;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  utf8tc_pkg::in_word_t src_word = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  utf8tc_pkg::out_word_t dst_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [utf8tc_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Transcoder state as the testbench predicts it.
  logic [1:0] cur_mode = MODE_UTF16LE;
  logic [31:0] gather_buf = '0;
  int gather_cnt = 0;
  logic [2:0] sticky_err = NO_ERROR;

  utf8tc_pkg::out_word_t utf8_expect_q[$];
  int mismatch_count = 0;
  int stream_words_sent = 0;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold_left = 0;

  utf16_utf32_to_utf8_transcoder uut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_word(src_word),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_word(dst_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic logic mode_is_big();
    return cur_mode == MODE_UTF16BE || cur_mode == MODE_UTF32BE;
  endfunction

  function automatic logic mode_is_utf32();
    return cur_mode == MODE_UTF32LE || cur_mode == MODE_UTF32BE;
  endfunction

  function automatic void expect_word(logic [7:0] b, logic is_last, logic [2:0] st);
    utf8tc_pkg::out_word_t w;
    w.out_byte = b;
    w.last = is_last;
    w.status = st;
    utf8_expect_q.push_back(w);
  endfunction

  function automatic void expect_utf8(logic [31:0] cp);
    logic [7:0] seq [6];
    logic [7:0] lead;
    logic [31:0] c;
    int n;
    int i;
    c = cp;
    if (c < 32'h80) begin
      expect_word(c[7:0], 1'b1, utf8tc_pkg::ST_BYTE);
      return;
    end
    if (c < 32'h800) n = 2;
    else if (c < 32'h10000) n = 3;
    else if (c < 32'h200000) n = 4;
    else if (c < 32'h4000000) n = 5;
    else n = 6;
    for (i = n - 1; i > 0; i--) begin
      seq[i] = {2'b10, c[5:0]};
      c = c >> 6;
    end
    lead = ~(8'hFF >> n);
    seq[0] = c[7:0] | lead;
    for (i = 0; i < n; i++) begin
      expect_word(seq[i], i == n - 1, utf8tc_pkg::ST_BYTE);
    end
  endfunction

  function automatic void clear_gather();
    gather_buf = '0;
    gather_cnt = 0;
  endfunction

  function automatic void flag_error(logic [2:0] st);
    sticky_err = st;
    clear_gather();
    expect_word(8'h00, 1'b1, st);
  endfunction

  function automatic void predict_transcode(utf8tc_pkg::in_word_t w);
    logic [15:0] first;
    logic [15:0] second;
    logic [31:0] value;
    logic [2:0] st;
    if (w.cmd) begin
      if (sticky_err != NO_ERROR) st = sticky_err;
      else if (gather_cnt != 0) st = utf8tc_pkg::ST_INCOMPLETE;
      else st = utf8tc_pkg::ST_CLEAN;
      clear_gather();
      sticky_err = NO_ERROR;
      expect_word(8'h00, 1'b1, st);
    end else if (sticky_err == NO_ERROR) begin
      gather_buf = {gather_buf[23:0], w.data_byte};
      gather_cnt++;
      if (!mode_is_utf32()) begin
        if (gather_cnt == 2) begin
          first = mode_is_big() ? gather_buf[15:0] : {gather_buf[7:0], gather_buf[15:8]};
          if (first >= 16'hDC00 && first < 16'hE000) begin
            flag_error(utf8tc_pkg::ST_ILLFORMED);
          end else if (first < 16'hD800 || first >= 16'hE000) begin
            clear_gather();
            expect_utf8({16'd0, first});
          end
        end else if (gather_cnt == 4) begin
          first = mode_is_big() ? gather_buf[31:16] : {gather_buf[23:16], gather_buf[31:24]};
          second = mode_is_big() ? gather_buf[15:0] : {gather_buf[7:0], gather_buf[15:8]};
          if (second < 16'hDC00 || second >= 16'hE000) begin
            flag_error(utf8tc_pkg::ST_ILLFORMED);
          end else begin
            clear_gather();
            value = {12'd0, first[9:0], second[9:0]} + 32'h10000;
            expect_utf8(value);
          end
        end
      end else if (gather_cnt == 4) begin
        value = mode_is_big() ? gather_buf :
                {gather_buf[7:0], gather_buf[15:8], gather_buf[23:16], gather_buf[31:24]};
        if (value[31]) begin
          flag_error(utf8tc_pkg::ST_UNENCODABLE);
        end else begin
          clear_gather();
          expect_utf8(value);
        end
      end
    end
  endfunction

  task automatic push_word(logic cmd, logic [7:0] b);
    utf8tc_pkg::in_word_t w;
    w.cmd = cmd;
    w.data_byte = b;
    while ($urandom_range(99) < src_gap_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word <= w;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    if (cmd || sticky_err == NO_ERROR) stream_words_sent++;
    predict_transcode(w);
  endtask

  task automatic send_unit16(logic [15:0] u);
    if (mode_is_big()) begin
      push_word(1'b0, u[15:8]);
      push_word(1'b0, u[7:0]);
    end else begin
      push_word(1'b0, u[7:0]);
      push_word(1'b0, u[15:8]);
    end
  endtask

  task automatic send_unit32(logic [31:0] v);
    int i;
    for (i = 0; i < 4; i++) begin
      push_word(1'b0, mode_is_big() ? v[31 - 8 * i -: 8] : v[8 * i +: 8]);
    end
  endtask

  task automatic drain_block();
    src_valid <= 1'b0;
    while (utf8_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [utf8tc_pkg::PADDR_W-1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ENC_MODE_ADDR) begin
      cur_mode = value[1:0];
      clear_gather();
    end
  endtask

  task automatic check_encoding_mode();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ENC_MODE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[1:0] !== cur_mode) begin
      report_mismatch($sformatf("encoding_mode read %0d, expected %0d", prdata[1:0], cur_mode));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_utf16_step();
    logic [15:0] u;
    int r;
    r = $urandom_range(99);
    if (r < 12) begin
      send_unit16(16'($urandom_range(16'h7F, 0)));
    end else if (r < 22) begin
      send_unit16(16'($urandom_range(16'h7FF, 16'h80)));
    end else if (r < 32) begin
      u = 16'($urandom_range(16'hF7FF, 16'h800));
      if (u >= 16'hD800) u = u + 16'h800;
      send_unit16(u);
    end else if (r < 62) begin
      send_unit16(16'($urandom_range(16'hDBFF, 16'hD800)));
      send_unit16(16'($urandom_range(16'hDFFF, 16'hDC00)));
    end else if (r < 68) begin
      send_unit16(16'($urandom_range(16'hDFFF, 16'hDC00)));
    end else if (r < 74) begin
      send_unit16(16'($urandom_range(16'hDBFF, 16'hD800)));
      u = 16'($urandom_range(16'hFFFF, 0));
      if (u >= 16'hDC00 && u < 16'hE000) u = u ^ 16'h2000;
      send_unit16(u);
    end else if (r < 78) begin
      send_unit16(16'($urandom_range(16'hDBFF, 16'hD800)));
      push_word(1'b1, 8'($urandom));
    end else if (r < 88) begin
      push_word(1'b1, 8'($urandom));
    end else begin
      push_word(1'b0, 8'($urandom));
    end
  endtask

  task automatic random_utf32_step();
    logic [31:0] v;
    int r;
    r = $urandom_range(99);
    if (r < 74) begin
      if (r < 10) v = $urandom_range(32'h7F, 0);
      else if (r < 20) v = $urandom_range(32'h7FF, 32'h80);
      else if (r < 30) v = $urandom_range(32'hFFFF, 32'h800);
      else if (r < 36) v = $urandom_range(32'hDFFF, 32'hD800);
      else if (r < 48) v = $urandom_range(32'h1FFFFF, 32'h10000);
      else if (r < 58) v = $urandom_range(32'h3FFFFFF, 32'h200000);
      else if (r < 68) v = $urandom_range(32'h7FFFFFFF, 32'h4000000);
      else v = $urandom | 32'h8000_0000;
      send_unit32(v);
    end else if (r < 84) begin
      push_word(1'b1, 8'($urandom));
    end else begin
      push_word(1'b0, 8'($urandom));
    end
  endtask

  // After an error most steps close the stream, since further data is dropped.
  task automatic random_step();
    if (sticky_err != NO_ERROR) begin
      push_word($urandom_range(3) != 0, 8'($urandom));
    end else if (mode_is_utf32()) begin
      random_utf32_step();
    end else begin
      random_utf16_step();
    end
  endtask

  task automatic test_utf16_boundaries();
    check_encoding_mode();
    send_unit16(16'h0000);
    send_unit16(16'hFFFF);
    send_unit16(16'hDBFF);
    send_unit16(16'hDFFF);
    push_word(1'b1, 8'hFF);
    push_word(1'b0, 8'h41);
    push_word(1'b1, 8'h00);
  endtask

  task automatic test_surrogate_errors();
    send_unit16(16'hDC00);
    push_word(1'b0, 8'h41);
    push_word(1'b1, 8'h00);
    send_unit16(16'hD800);
    send_unit16(16'h0041);
    push_word(1'b1, 8'h00);
  endtask

  task automatic test_utf32_extremes();
    drain_block();
    write_register(ENC_MODE_ADDR, {30'd0, MODE_UTF32BE});
    write_register(SPARE_ADDR, {30'd0, MODE_UTF32LE});
    check_encoding_mode();
    send_unit32(32'h7FFF_FFFF);
    send_unit32(32'h8000_0000);
    drain_block();
    // The sticky error survives a register write.
    write_register(ENC_MODE_ADDR, {30'd0, MODE_UTF32LE});
    push_word(1'b1, 8'h00);
    send_unit32(32'h0000_D800);
    push_word(1'b1, 8'h00);
  endtask

  task automatic test_random_traffic(int gap_pct, int stall_pct, int words_per_mode);
    logic [1:0] order_key;
    logic [1:0] mode;
    int m;
    int target;
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    order_key = 2'($urandom_range(3));
    for (m = 0; m < 4; m++) begin
      mode = 2'(m) ^ order_key;
      drain_block();
      write_register(ENC_MODE_ADDR, ($urandom & 32'hFFFF_FFFC) | {30'd0, mode});
      check_encoding_mode();
      target = stream_words_sent + words_per_mode;
      while (stream_words_sent < target) random_step();
      if ($urandom_range(1) != 0) push_word(1'b1, 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    int target;
    drain_block();
    write_register(ENC_MODE_ADDR, {30'd0, MODE_UTF16BE});
    src_gap_pct = 0;
    sink_stall_pct = 0;
    sink_hold_left = 300;
    target = stream_words_sent + 40;
    while (stream_words_sent < target) random_step();
    push_word(1'b1, 8'h00);
  endtask

  always @(posedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      dst_stall <= 1'b1;
    end else begin
      dst_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_output
    utf8tc_pkg::out_word_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (utf8_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: byte %02h last %0d status %0d",
                                  dst_word.out_byte, dst_word.last, dst_word.status));
      end else begin
        want = utf8_expect_q.pop_front();
        if (dst_word.out_byte !== want.out_byte || dst_word.last !== want.last ||
            dst_word.status !== want.status) begin
          report_mismatch($sformatf(
            "expected byte %02h last %0d status %0d, got byte %02h last %0d status %0d",
            want.out_byte, want.last, want.status,
            dst_word.out_byte, dst_word.last, dst_word.status));
        end
      end
    end
  end

  initial begin
    src_gap_pct = 9;
    sink_stall_pct = 79;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    cur_mode = MODE_UTF16LE;
    clear_gather();
    sticky_err = NO_ERROR;
    test_utf16_boundaries();
    test_surrogate_errors();
    test_utf32_extremes();
    test_random_traffic(9, 79, 15);
    test_random_traffic(79, 9, 15);
    test_random_traffic(0, 0, 15);
    test_backpressure();
    drain_block();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
